// ===== hdl/crp_pkg.sv =====
// Package: shared constants and types for the table seating sampler.
`timescale 1ns / 1ps
package crp_pkg;
  localparam int unsigned MaxGroupsDefault = 64;
  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned HeldBits = 16;
  localparam logic OpAdd = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_SUM   = 11'b00000000010,
    ST_MUL0  = 11'b00000000100,
    ST_MUL1  = 11'b00000001000,
    ST_MUL2  = 11'b00000010000,
    ST_SCAN  = 11'b00000100000,
    ST_CMP   = 11'b00001000000,
    ST_WRITE = 11'b00010000000,
    ST_SHIFT = 11'b00100000000,
    ST_SHWR  = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;
endpackage

// ===== hdl/crp_table_seating_sampler_unit.sv =====
// Top level: table seating sampler with group counts in one synchronous memory.
`timescale 1ns / 1ps
// One transaction in, one transaction out. The group counts sit in a memory with
// one write port and a registered read port, so each item walks the list entry by
// entry: it totals the counts of the groups in use, forms the product in states
// MUL0, MUL1 and MUL2, scans the groups, writes back, shifts every later entry
// down when a delete empties a group and then issues the result. Errors and the
// first add go straight to issuing the result. The next item can be accepted in
// the same cycle as the result appears. One item is in work at a time; a held
// result does not block acceptance of the next item, only the issue of its result.
module crp_table_seating_sampler_unit
  import crp_pkg::*;
#(
  parameter int unsigned MAX_GROUPS = MaxGroupsDefault,
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_new_weight,
  input  logic [19:0] in_total_customers,
  input  logic [15:0] in_random_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_new_group,
  output logic        out_group_removed,
  output logic [5:0]  out_chosen_group,
  output logic [6:0]  out_groups_in_use,
  output logic [15:0] out_customers_held,
  output logic        out_error
);
  localparam int unsigned AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned TW = $clog2(MAX_GROUPS + 1);
  localparam int unsigned SW = COUNT_BITS + AW;
  localparam int unsigned UW = SW + 16;
  localparam int unsigned HW = (UW + 1) / 2;
  localparam int unsigned LW = 16 + SW + 37;
  localparam int unsigned RW = 20 + SW + 32;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [COUNT_BITS-1:0] mem [MAX_GROUPS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;
  logic [AW-1:0]         mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  state_t state_r, state_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [15:0] held_r, held_nxt;
  logic op_r, op_nxt;
  logic [31:0] w_r, w_nxt;
  logic [19:0] n_r, n_nxt;
  logic [15:0] u_r, u_nxt;
  logic [TW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [UW-1:0] us_r, us_nxt;
  logic [LW-1:0] lhs_r, lhs_nxt;
  logic [SW-1:0] rsel_r, rsel_nxt;
  logic [RW-1:0] rhs_r, rhs_nxt;
  logic [COUNT_BITS-1:0] cur_r, cur_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic ov_r, ov_nxt;
  logic made_r, made_nxt, rmv_r, rmv_nxt, err_r, err_nxt;
  logic [5:0] chosen_r, chosen_nxt;

  logic        res_made_r, res_rmv_r, res_err_r;
  logic [5:0]  res_chosen_r;
  logic [6:0]  res_used_r;
  logic [15:0] res_held_r;
  logic        res_load;

  logic [TW-1:0] idx_inc;
  logic [SW-1:0] cum;
  logic          last;
  logic [HW-1:0] mul_a;
  logic [36:0]   mul_m;
  logic [HW+36:0] mul_p;

  assign idx_inc = idx_r + TW'(1);
  assign cum = acc_r + SW'(rd_data_r);
  assign last = (idx_inc == total_r);
  assign in_ready = (state_r == ST_IDLE);
  assign mem_ra = idx_nxt[AW-1:0];
  assign res_load = (state_r == ST_OUT) && (!ov_r || out_ready);

  // u*(S+op)*(N*2^16+w) formed in two halves of u*(S+op) on one shared multiplier
  assign mul_m = {1'b0, n_r, 16'd0} + {5'd0, w_r};
  assign mul_a = (state_r == ST_MUL2) ? HW'(us_r[UW-1:HW]) : us_r[HW-1:0];
  assign mul_p = (HW + 37)'(mul_a) * (HW + 37)'(mul_m);

  assign out_valid = ov_r;
  assign out_new_group = res_made_r;
  assign out_group_removed = res_rmv_r;
  assign out_chosen_group = res_chosen_r;
  assign out_groups_in_use = res_used_r;
  assign out_customers_held = res_held_r;
  assign out_error = res_err_r;

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    held_nxt = held_r;
    op_nxt = op_r;
    w_nxt = w_r;
    n_nxt = n_r;
    u_nxt = u_r;
    idx_nxt = idx_r;
    acc_nxt = acc_r;
    us_nxt = us_r;
    lhs_nxt = lhs_r;
    rsel_nxt = rsel_r;
    rhs_nxt = rhs_r;
    cur_nxt = cur_r;
    tgt_nxt = tgt_r;
    ov_nxt = ov_r;
    made_nxt = made_r;
    rmv_nxt = rmv_r;
    err_nxt = err_r;
    chosen_nxt = chosen_r;
    mem_we = 1'b0;
    mem_wa = tgt_r;
    mem_wd = cur_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_op;
          w_nxt = in_new_weight;
          n_nxt = in_total_customers;
          u_nxt = in_random_fraction;
          made_nxt = 1'b0;
          rmv_nxt = 1'b0;
          err_nxt = 1'b0;
          chosen_nxt = '0;
          idx_nxt = '0;
          acc_nxt = '0;
          if (in_op == OpAdd) begin
            if (32'(total_r) >= MAX_GROUPS) begin
              err_nxt = 1'b1;
              state_nxt = ST_OUT;
            end else if (total_r == '0) begin
              mem_we = 1'b1;
              mem_wa = '0;
              mem_wd = COUNT_BITS'(1);
              total_nxt = TW'(1);
              made_nxt = 1'b1;
              if (held_r != '1) held_nxt = held_r + 16'd1;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_SUM;
            end
          end else begin
            if (total_r == '0) begin
              err_nxt = 1'b1;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        acc_nxt = cum;
        idx_nxt = idx_inc;
        if (last) begin
          idx_nxt = '0;
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        us_nxt = UW'(u_r) * UW'(acc_r + SW'(op_r));
        acc_nxt = '0;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        lhs_nxt = LW'(mul_p);
        rsel_nxt = SW'(us_r >> 16);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        lhs_nxt = lhs_r + (LW'(mul_p) << HW);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        acc_nxt = cum;
        cur_nxt = rd_data_r;
        rhs_nxt = RW'(n_r) * RW'(cum);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        tgt_nxt = idx_r[AW-1:0];
        chosen_nxt = 6'(idx_r);
        if (op_r == OpAdd) begin
          if (LW'(lhs_r) <= (LW'(rhs_r) << 32)) begin
            if (cur_r != CntMax) cur_nxt = cur_r + COUNT_BITS'(1);
            state_nxt = ST_WRITE;
          end else if (last) begin
            tgt_nxt = total_r[AW-1:0];
            chosen_nxt = 6'(total_r);
            cur_nxt = COUNT_BITS'(1);
            total_nxt = total_r + TW'(1);
            made_nxt = 1'b1;
            state_nxt = ST_WRITE;
          end else begin
            idx_nxt = idx_inc;
            state_nxt = ST_SCAN;
          end
          if (state_nxt == ST_WRITE && held_r != '1) held_nxt = held_r + 16'd1;
        end else begin
          if (rsel_r <= acc_r || last) begin
            if (cur_r != '0) cur_nxt = cur_r - COUNT_BITS'(1);
            if (held_r != '0) held_nxt = held_r - 16'd1;
            state_nxt = ST_WRITE;
          end else begin
            idx_nxt = idx_inc;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_WRITE: begin
        if (cur_r == '0 && op_r == OpRemove) begin
          rmv_nxt = 1'b1;
          total_nxt = total_r - TW'(1);
          idx_nxt = idx_inc;
          state_nxt = last ? ST_OUT : ST_SHIFT;
        end else begin
          mem_we = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_SHIFT: begin
        state_nxt = ST_SHWR;
      end
      ST_SHWR: begin
        mem_we = 1'b1;
        mem_wa = tgt_r;
        mem_wd = rd_data_r;
        tgt_nxt = tgt_r + AW'(1);
        idx_nxt = idx_inc;
        state_nxt = (idx_r == total_r) ? ST_OUT : ST_SHIFT;
      end
      ST_OUT: begin
        if (res_load) begin
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
      held_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      held_r <= held_nxt;
      ov_r <= ov_nxt;
    end
    op_r <= op_nxt;
    w_r <= w_nxt;
    n_r <= n_nxt;
    u_r <= u_nxt;
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    us_r <= us_nxt;
    lhs_r <= lhs_nxt;
    rsel_r <= rsel_nxt;
    rhs_r <= rhs_nxt;
    cur_r <= cur_nxt;
    tgt_r <= tgt_nxt;
    made_r <= made_nxt;
    rmv_r <= rmv_nxt;
    err_r <= err_nxt;
    chosen_r <= chosen_nxt;
    if (res_load) begin
      res_made_r <= made_r;
      res_rmv_r <= rmv_r;
      res_err_r <= err_r;
      res_chosen_r <= chosen_r;
      res_used_r <= 7'(total_r);
      res_held_r <= held_r;
    end
  end

`ifndef SYNTH
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= MAX_GROUPS) else $error("group total beyond capacity");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_new_group && out_group_removed))
    else $error("new and removed both set");
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (!out_new_group && !out_group_removed))
    else $error("error result with change flags");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted item not started");
`endif
endmodule
